// ===== hw/rtl/pubgate_pkg.sv =====
// ----------------------------------------------------------------------------
// pubgate_pkg
// Types and constants shared by the publication handshake gate.
// ----------------------------------------------------------------------------
package pubgate_pkg;

  localparam int unsigned CmdWidth      = 3;
  localparam int unsigned StatusWidth   = 3;
  localparam int unsigned PhaseWidth    = 3;
  localparam int unsigned ManifestWidth = 32;
  localparam int unsigned SnapshotWidth = 64;

  typedef enum logic [CmdWidth-1:0] {
    CMD_REQUIRE_MANIFEST = 3'd0,
    CMD_MANIFEST_APPLIED = 3'd1,
    CMD_BEGIN_SNAPSHOT   = 3'd2,
    CMD_SNAPSHOT_APPLIED = 3'd3,
    CMD_QUERY_DELTA      = 3'd4,
    CMD_FAULT            = 3'd5,
    CMD_SOFT_RESET       = 3'd6
  } cmd_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_ACCEPTED     = 3'd0,
    ST_FAULTED      = 3'd1,
    ST_BAD_MANIFEST = 3'd2,
    ST_NOT_READY    = 3'd3,
    ST_BAD_SNAPSHOT = 3'd4
  } status_t;

  // Encoded phase as it appears on the result word.
  localparam logic [PhaseWidth-1:0] PHC_AWAIT_MANIFEST  = 3'd0;
  localparam logic [PhaseWidth-1:0] PHC_READY_SNAPSHOT  = 3'd1;
  localparam logic [PhaseWidth-1:0] PHC_AWAIT_SNAP_DONE = 3'd2;
  localparam logic [PhaseWidth-1:0] PHC_READY_DELTAS    = 3'd3;
  localparam logic [PhaseWidth-1:0] PHC_FAULTED         = 3'd4;

  // Internal phase state, one-hot.
  typedef enum logic [4:0] {
    PH_AWAIT_MANIFEST  = 5'b00001,
    PH_READY_SNAPSHOT  = 5'b00010,
    PH_AWAIT_SNAP_DONE = 5'b00100,
    PH_READY_DELTAS    = 5'b01000,
    PH_FAULTED         = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CmdWidth-1:0]      command;
    logic [ManifestWidth-1:0] manifest_tag;
    logic [SnapshotWidth-1:0] snapshot_tag;
  } in_word_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [PhaseWidth-1:0]  phase;
  } out_word_t;

  typedef struct packed {
    phase_t                   phase;
    logic [ManifestWidth-1:0] required_manifest;
    logic [SnapshotWidth-1:0] pending_snapshot;
  } gate_state_t;

  function automatic logic [PhaseWidth-1:0] phase_code(phase_t ph);
    logic [PhaseWidth-1:0] code;
    case (ph)
      PH_AWAIT_MANIFEST:  code = PHC_AWAIT_MANIFEST;
      PH_READY_SNAPSHOT:  code = PHC_READY_SNAPSHOT;
      PH_AWAIT_SNAP_DONE: code = PHC_AWAIT_SNAP_DONE;
      PH_READY_DELTAS:    code = PHC_READY_DELTAS;
      PH_FAULTED:         code = PHC_FAULTED;
      default:            code = PHC_AWAIT_MANIFEST;
    endcase
    return code;
  endfunction

endpackage

// ===== hw/rtl/pubgate_step.sv =====
// ----------------------------------------------------------------------------
// pubgate_step
// Decides the status of one event and the gate state that follows it.
// ----------------------------------------------------------------------------
module pubgate_step (
  input  pubgate_pkg::in_word_t    word,
  input  pubgate_pkg::gate_state_t cur,
  output pubgate_pkg::gate_state_t nxt,
  output pubgate_pkg::out_word_t   result
);

  pubgate_pkg::status_t status;
  logic                 faulted;
  logic                 mid_zero;
  logic                 sid_zero;
  logic                 mid_match;
  logic                 sid_match;

  assign faulted   = (cur.phase == pubgate_pkg::PH_FAULTED);
  assign mid_zero  = (word.manifest_tag == '0);
  assign sid_zero  = (word.snapshot_tag == '0);
  assign mid_match = (word.manifest_tag == cur.required_manifest);
  assign sid_match = (word.snapshot_tag == cur.pending_snapshot);

  // A rejected event leaves the state as it is.
  always_comb begin
    nxt    = cur;
    status = pubgate_pkg::ST_ACCEPTED;
    case (word.command)
      pubgate_pkg::CMD_REQUIRE_MANIFEST: begin
        if (faulted) begin
          status = pubgate_pkg::ST_FAULTED;
        end else if (mid_zero) begin
          status = pubgate_pkg::ST_BAD_MANIFEST;
        end else begin
          nxt.required_manifest = word.manifest_tag;
          nxt.pending_snapshot  = '0;
          nxt.phase             = pubgate_pkg::PH_AWAIT_MANIFEST;
        end
      end
      pubgate_pkg::CMD_MANIFEST_APPLIED: begin
        if (faulted) begin
          status = pubgate_pkg::ST_FAULTED;
        end else if (cur.phase != pubgate_pkg::PH_AWAIT_MANIFEST) begin
          status = pubgate_pkg::ST_NOT_READY;
        end else if (mid_zero || !mid_match) begin
          status = pubgate_pkg::ST_BAD_MANIFEST;
        end else begin
          nxt.phase = pubgate_pkg::PH_READY_SNAPSHOT;
        end
      end
      pubgate_pkg::CMD_BEGIN_SNAPSHOT: begin
        if (faulted) begin
          status = pubgate_pkg::ST_FAULTED;
        end else if (cur.phase != pubgate_pkg::PH_READY_SNAPSHOT) begin
          status = pubgate_pkg::ST_NOT_READY;
        end else if (sid_zero) begin
          status = pubgate_pkg::ST_BAD_SNAPSHOT;
        end else begin
          nxt.pending_snapshot = word.snapshot_tag;
          nxt.phase            = pubgate_pkg::PH_AWAIT_SNAP_DONE;
        end
      end
      pubgate_pkg::CMD_SNAPSHOT_APPLIED: begin
        if (faulted) begin
          status = pubgate_pkg::ST_FAULTED;
        end else if (cur.phase != pubgate_pkg::PH_AWAIT_SNAP_DONE) begin
          status = pubgate_pkg::ST_NOT_READY;
        end else if (!mid_match) begin
          status = pubgate_pkg::ST_BAD_MANIFEST;
        end else if (sid_zero || !sid_match) begin
          status = pubgate_pkg::ST_BAD_SNAPSHOT;
        end else begin
          nxt.pending_snapshot = '0;
          nxt.phase            = pubgate_pkg::PH_READY_DELTAS;
        end
      end
      pubgate_pkg::CMD_QUERY_DELTA: begin
        if (cur.phase == pubgate_pkg::PH_READY_DELTAS) begin
          status = pubgate_pkg::ST_ACCEPTED;
        end else if (faulted) begin
          status = pubgate_pkg::ST_FAULTED;
        end else begin
          status = pubgate_pkg::ST_NOT_READY;
        end
      end
      pubgate_pkg::CMD_FAULT: begin
        nxt.pending_snapshot = '0;
        nxt.phase            = pubgate_pkg::PH_FAULTED;
      end
      pubgate_pkg::CMD_SOFT_RESET: begin
        nxt.required_manifest = '0;
        nxt.pending_snapshot  = '0;
        nxt.phase             = pubgate_pkg::PH_AWAIT_MANIFEST;
      end
      default: begin
        status = pubgate_pkg::ST_NOT_READY;
      end
    endcase
  end

  assign result.status = status;
  assign result.phase  = pubgate_pkg::phase_code(nxt.phase);

endmodule

// ===== hw/rtl/publication_handshake_gate_core.sv =====
// ----------------------------------------------------------------------------
// publication_handshake_gate_core
// Orders manifest and snapshot events before delta publication is allowed.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the in_ channel (valid/ready) as one in_word_t word:
//   command, manifest id and snapshot id. Every event yields exactly one
//   result word on the out_ channel: a status code and the phase after the
//   event. Events are handled strictly in order.
//   An accepted event lands in an input register; when the result
//   register is free or being emptied, it is decided against the gate
//   state and written to the result register, raising out_valid. One event
//   is taken every cycle as long as results are taken; the rate is set by
//   the single decision stage between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only while both are occupied and
//   out_ready is low. Nothing is dropped or repeated.
//   Reset empties both registers and puts the gate in the await-manifest
//   phase with both stored ids cleared.
// ----------------------------------------------------------------------------
module publication_handshake_gate_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pubgate_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pubgate_pkg::out_word_t out_data
);

  logic                     s1_valid_r;
  pubgate_pkg::in_word_t    s1_word_r;
  logic                     out_valid_r;
  pubgate_pkg::out_word_t   out_word_r;
  pubgate_pkg::gate_state_t state_r;
  pubgate_pkg::gate_state_t state_nxt;
  pubgate_pkg::out_word_t   result_nxt;
  logic                     advance;
  logic                     decide;

  // The decision stage moves whenever the result register is free or
  // is being emptied this cycle.
  assign advance  = !out_valid_r || out_ready;
  assign decide   = advance && s1_valid_r;
  assign in_ready = !s1_valid_r || advance;

  pubgate_step u_step (
    .word   (s1_word_r),
    .cur    (state_r),
    .nxt    (state_nxt),
    .result (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r                <= 1'b0;
      out_valid_r               <= 1'b0;
      state_r.phase             <= pubgate_pkg::PH_AWAIT_MANIFEST;
      state_r.required_manifest <= '0;
      state_r.pending_snapshot  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (decide) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_data;
    end
    if (decide) begin
      out_word_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Only a snapshot in flight may leave a nonzero pending id behind.
  a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != pubgate_pkg::PH_AWAIT_SNAP_DONE |-> state_r.pending_snapshot == '0)
    else $error("pending snapshot id left outside await-snapshot-applied phase");

  // Past the manifest step the required manifest must be a valid id.
  a_manifest_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == pubgate_pkg::PH_READY_SNAPSHOT ||
     state_r.phase == pubgate_pkg::PH_AWAIT_SNAP_DONE ||
     state_r.phase == pubgate_pkg::PH_READY_DELTAS) |-> state_r.required_manifest != '0)
    else $error("handshake advanced without a required manifest");

  // A faulted status is only ever reported alongside the faulted phase.
  a_fault_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.status == pubgate_pkg::ST_FAULTED |->
      out_word_r.phase == pubgate_pkg::PHC_FAULTED)
    else $error("faulted status with a phase other than faulted");

  // The gate state moves only when an event is decided.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !decide |=> $stable(state_r))
    else $error("gate state changed without a decided event");

  // A decided event always leaves a result in the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    decide |=> out_valid_r)
    else $error("decided event produced no result");

endmodule
